@@ hdl/tspi_pkg.sv @@
`timescale 1ns / 1ps
package tspi_pkg;

  localparam int STAMP_W   = 63;
  localparam int LANE_W    = 32;
  localparam int MAX_LANES = 4;
  localparam int MAG_W     = LANE_W + 1;
  localparam int STEP_W    = 6;

  typedef logic signed [LANE_W-1:0] lane_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;

  localparam kind_t KIND_APPEND = 2'd0;
  localparam kind_t KIND_REMOVE = 2'd1;
  localparam kind_t KIND_QUERY  = 2'd2;
  localparam kind_t KIND_READ   = 2'd3;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_LATER = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FEW       = 3'd3;
  localparam status_t ST_SPAN      = 3'd4;
  localparam status_t ST_TOO_MANY  = 3'd5;

endpackage

@@ hdl/tspi_in_if.sv @@
`timescale 1ns / 1ps
interface tspi_in_if #(parameter int CW = 9);
  logic                    valid;
  logic                    ready;
  tspi_pkg::kind_t         kind;
  tspi_pkg::stamp_t        time_us;
  logic [CW-1:0]           index_or_count;
  tspi_pkg::lane_t         in_lane_0;
  tspi_pkg::lane_t         in_lane_1;
  tspi_pkg::lane_t         in_lane_2;
  tspi_pkg::lane_t         in_lane_3;

  modport source (output valid, kind, time_us, index_or_count,
                  in_lane_0, in_lane_1, in_lane_2, in_lane_3, input ready);
  modport sink   (input valid, kind, time_us, index_or_count,
                  in_lane_0, in_lane_1, in_lane_2, in_lane_3, output ready);
endinterface

@@ hdl/tspi_out_if.sv @@
`timescale 1ns / 1ps
interface tspi_out_if #(parameter int CW = 9);
  logic                    valid;
  logic                    ready;
  tspi_pkg::status_t       status;
  logic                    exact_match;
  tspi_pkg::stamp_t        out_time_us;
  tspi_pkg::lane_t         out_lane_0;
  tspi_pkg::lane_t         out_lane_1;
  tspi_pkg::lane_t         out_lane_2;
  tspi_pkg::lane_t         out_lane_3;
  logic [CW-1:0]           entry_count;

  modport source (output valid, status, exact_match, out_time_us, out_lane_0, out_lane_1,
                  out_lane_2, out_lane_3, entry_count, input ready);
  modport sink   (input valid, status, exact_match, out_time_us, out_lane_0, out_lane_1,
                  out_lane_2, out_lane_3, entry_count, output ready);
endinterface

@@ hdl/timestamped_sample_interpolator_top.sv @@
`timescale 1ns / 1ps
// Time-ordered ring of up to DEPTH timestamped sample vectors held in two
// synchronous memories (stamps, vectors), each with one read and one write port.
// One word is processed at a time. A query runs a binary search over the
// stored stamps, then fetches the two neighbors and runs the bit-serial
// scale-and-divide (one unit per lane, all lanes together). The result
// register frees the block once a result is loaded.
// The interfaces take CW = $clog2(DEPTH+1).
module timestamped_sample_interpolator_top #(
  parameter int DEPTH = 256,
  parameter int LANES = 4
) (
  input logic clk,
  input logic rst,
  tspi_in_if.sink    in_ch,
  tspi_out_if.source out_ch
);
  import tspi_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = LANES * LANE_W;
  localparam logic [CW:0] DEPTH_W = (CW+1)'(DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_W - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_APP  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_QF   = 4'd3;
  localparam logic [3:0] S_QL   = 4'd4;
  localparam logic [3:0] S_QS   = 4'd5;
  localparam logic [3:0] S_QC   = 4'd6;
  localparam logic [3:0] S_QR   = 4'd7;
  localparam logic [3:0] S_QH   = 4'd8;
  localparam logic [3:0] S_QLO  = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_QEND = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, base} + {1'b0, i};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  logic [3:0]    state;
  logic [AW-1:0] oldest;
  logic [CW-1:0] count;

  stamp_t        t;
  logic [VW-1:0] lanes_in;

  stamp_t        stamp_mem [DEPTH];
  logic [VW-1:0] vec_mem [DEPTH];
  stamp_t        stamp_rd;
  logic [VW-1:0] vec_rd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  logic [CW-1:0] lo, hi, mid;
  logic [CW:0]   mid_sum;
  stamp_t        first_stamp, stamp_hi;
  logic [VW-1:0] vec_hi;

  stamp_t        dd, dp;
  logic [MAG_W-1:0] dm [LANES];
  logic [MAG_W-1:0] dq [LANES];
  stamp_t           dr [LANES];
  lane_t            da [LANES];
  logic             dneg [LANES];
  logic [MAG_W-1:0] nq [LANES];
  stamp_t           nr [LANES];
  logic [STEP_W-1:0] step;

  status_t r_status;
  logic    r_exact;
  stamp_t  r_time;
  lane_t   r_lanes [MAX_LANES];

  logic    out_valid;
  status_t o_status;
  logic    o_exact;
  stamp_t  o_time;
  lane_t   o_lanes [MAX_LANES];
  logic [CW-1:0] o_count;

  logic    in_fire;

  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    case (state)
      S_IDLE: begin
        case (in_ch.kind)
          KIND_APPEND: rd_addr = slot_of(oldest, count - CW'(1));
          KIND_READ:   rd_addr = slot_of(oldest, in_ch.index_or_count);
          default:     rd_addr = oldest;
        endcase
      end
      S_QF:    rd_addr = slot_of(oldest, count - CW'(1));
      S_QS:    rd_addr = slot_of(oldest, mid);
      S_QR:    rd_addr = slot_of(oldest, lo);
      S_QH:    rd_addr = slot_of(oldest, lo - CW'(1));
      default: rd_addr = oldest;
    endcase
  end

  assign wr_addr = slot_of(oldest, count);
  assign wr_en   = (state == S_APP) && !(count != '0 && t <= stamp_rd)
                   && ({1'b0, count} != DEPTH_W);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= t;
      vec_mem[wr_addr]   <= lanes_in;
    end
    stamp_rd <= stamp_mem[rd_addr];
    vec_rd   <= vec_mem[rd_addr];
  end

  // one bit of m per step: q,r track floor(x*p/d) for the bits seen so far
  always_comb begin
    logic [STAMP_W:0] r2;
    logic [MAG_W-1:0] q2;
    for (int l = 0; l < LANES; l++) begin
      r2 = {dr[l], 1'b0};
      q2 = {dq[l][MAG_W-2:0], 1'b0};
      if (r2 >= {1'b0, dd}) begin
        r2 = r2 - {1'b0, dd};
        q2 = q2 + MAG_W'(1);
      end
      if (dm[l][MAG_W-1]) begin
        r2 = r2 + {1'b0, dp};
        if (r2 >= {1'b0, dd}) begin
          r2 = r2 - {1'b0, dd};
          q2 = q2 + MAG_W'(1);
        end
      end
      nq[l] = q2;
      nr[l] = r2[STAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [LANE_W+2:0] res;
    logic signed [MAG_W:0]    diff;
    if (rst) begin
      state     <= S_IDLE;
      oldest    <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            t <= in_ch.time_us;
            lanes_in[0 +: LANE_W] <= in_ch.in_lane_0;
            if (LANES > 1) lanes_in[(1%LANES)*LANE_W +: LANE_W] <= in_ch.in_lane_1;
            if (LANES > 2) lanes_in[(2%LANES)*LANE_W +: LANE_W] <= in_ch.in_lane_2;
            if (LANES > 3) lanes_in[(3%LANES)*LANE_W +: LANE_W] <= in_ch.in_lane_3;
            r_exact  <= 1'b0;
            r_time   <= '0;
            for (int l = 0; l < MAX_LANES; l++) r_lanes[l] <= '0;
            case (in_ch.kind)
              KIND_APPEND: begin
                r_status <= ST_OK;
                state    <= S_APP;
              end
              KIND_REMOVE: begin
                if (in_ch.index_or_count > count) begin
                  r_status <= ST_TOO_MANY;
                end else begin
                  r_status <= ST_OK;
                  oldest <= slot_of(oldest, in_ch.index_or_count);
                  count  <= count - in_ch.index_or_count;
                end
                state <= S_OUT;
              end
              KIND_QUERY: begin
                if (count < CW'(2)) begin
                  r_status <= ST_FEW;
                  state    <= S_OUT;
                end else begin
                  r_status <= ST_OK;
                  state    <= S_QF;
                end
              end
              default: begin
                if (in_ch.index_or_count >= count) begin
                  r_status <= ST_SPAN;
                  state    <= S_OUT;
                end else begin
                  r_status <= ST_OK;
                  state    <= S_RD;
                end
              end
            endcase
          end
        end
        S_APP: begin
          if (count != '0 && t <= stamp_rd) r_status <= ST_NOT_LATER;
          else if ({1'b0, count} == DEPTH_W) r_status <= ST_FULL;
          else count <= count + CW'(1);
          state <= S_OUT;
        end
        S_RD: begin
          r_time <= stamp_rd;
          for (int l = 0; l < LANES; l++) r_lanes[l] <= vec_rd[l*LANE_W +: LANE_W];
          state <= S_OUT;
        end
        S_QF: begin
          first_stamp <= stamp_rd;
          state       <= S_QL;
        end
        S_QL: begin
          if (t < first_stamp || t > stamp_rd) begin
            r_status <= ST_SPAN;
            state    <= S_OUT;
          end else begin
            lo    <= '0;
            hi    <= count - CW'(1);
            state <= S_QS;
          end
        end
        S_QS: state <= (lo == hi) ? S_QR : S_QC;
        S_QC: begin
          // first entry with stamp >= t
          if (stamp_rd >= t) hi <= mid;
          else lo <= mid + CW'(1);
          state <= S_QS;
        end
        S_QR: state <= S_QH;
        S_QH: begin
          stamp_hi <= stamp_rd;
          vec_hi   <= vec_rd;
          if (stamp_rd == t) begin
            r_exact <= 1'b1;
            for (int l = 0; l < LANES; l++) r_lanes[l] <= vec_rd[l*LANE_W +: LANE_W];
            state <= S_OUT;
          end else begin
            state <= S_QLO;
          end
        end
        S_QLO: begin
          dd <= stamp_hi - stamp_rd;
          dp <= t - stamp_rd;
          for (int l = 0; l < LANES; l++) begin
            diff = (MAG_W+1)'($signed(vec_hi[l*LANE_W +: LANE_W]))
                   - (MAG_W+1)'($signed(vec_rd[l*LANE_W +: LANE_W]));
            da[l]   <= vec_rd[l*LANE_W +: LANE_W];
            dneg[l] <= diff[MAG_W];
            dm[l]   <= diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
            dq[l]   <= '0;
            dr[l]   <= '0;
          end
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int l = 0; l < LANES; l++) begin
            dq[l] <= nq[l];
            dr[l] <= nr[l];
            dm[l] <= {dm[l][MAG_W-2:0], 1'b0};
          end
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) state <= S_QEND;
        end
        S_QEND: begin
          for (int l = 0; l < LANES; l++) begin
            if (dneg[l]) res = (LANE_W+3)'(da[l]) - (LANE_W+3)'($signed({2'b00, dq[l]}));
            else res = (LANE_W+3)'(da[l]) + (LANE_W+3)'($signed({2'b00, dq[l]}));
            if (res > (LANE_W+3)'(32'sh7fffffff)) r_lanes[l] <= 32'sh7fffffff;
            else if (res < -(LANE_W+3)'(33'sh080000000)) r_lanes[l] <= 32'sh80000000;
            else r_lanes[l] <= res[LANE_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ch.ready)) begin
      o_status <= r_status;
      o_exact  <= r_exact;
      o_time   <= r_time;
      o_lanes  <= r_lanes;
      o_count  <= count;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = o_status;
  assign out_ch.exact_match = o_exact;
  assign out_ch.out_time_us = o_time;
  assign out_ch.out_lane_0  = o_lanes[0];
  assign out_ch.out_lane_1  = o_lanes[1];
  assign out_ch.out_lane_2  = o_lanes[2];
  assign out_ch.out_lane_3  = o_lanes[3];
  assign out_ch.entry_count = o_count;

endmodule
